### rtl/core/pas_pkg.sv
`default_nettype none

package pas_pkg;

   // fixed geometry of the converter and of one burst
   localparam int ADC_BITS    = 12;
   localparam int AVG_SAMPLES = 16;
   localparam int AVG_SHIFT   = 4;
   localparam int SUM_W       = ADC_BITS + AVG_SHIFT;
   localparam int CNT_W       = 5;
   localparam int TICK_W      = 17;
   localparam int DIV_STEPS   = 16;
   localparam int DIV_CNT_W   = $clog2(DIV_STEPS);

   // item kinds carried on the request side
   localparam logic [1:0] KIND_TICK    = 2'd0;
   localparam logic [1:0] KIND_SAMPLE  = 2'd1;
   localparam logic [1:0] KIND_FAILURE = 2'd2;

   // status codes
   localparam logic [1:0] ST_NOT_READY = 2'd0;
   localparam logic [1:0] ST_OK        = 2'd1;
   localparam logic [1:0] ST_ERROR     = 2'd2;

   // register indexes
   localparam logic [2:0] REG_PERIOD   = 3'd0;
   localparam logic [2:0] REG_REF_MV   = 3'd1;
   localparam logic [2:0] REG_GAIN     = 3'd2;
   localparam logic [2:0] REG_ZERO_MV  = 3'd3;
   localparam logic [2:0] REG_FULL_MV  = 3'd4;
   localparam logic [2:0] REG_FULL_SC  = 3'd5;

   // register reset values
   localparam logic [15:0] RST_PERIOD  = 16'd100;
   localparam logic [12:0] RST_REF_MV  = 13'd3300;
   localparam logic [15:0] RST_GAIN    = 16'd256;
   localparam logic [15:0] RST_ZERO_MV = 16'd500;
   localparam logic [15:0] RST_FULL_MV = 16'd4500;
   localparam logic [15:0] RST_FULL_SC = 16'd100;

   typedef struct packed {
      logic [15:0] period_ms;
      logic [12:0] ref_mv;
      logic [15:0] gain_q8;
      logic [15:0] zero_mv;
      logic [15:0] full_mv;
      logic [15:0] full_scale_centi;
   } cfg_type;

   // controller to datapath
   typedef struct packed {
      logic accept;
      logic mul_a;
      logic mul_b;
      logic diff;
      logic mul_c;
      logic sum;
      logic div_step;
      logic write_press;
      logic load_out;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic finish;
   } sts_type;

   // millivolts times full scale code times 256: (x * 4095) << 8 by shift and subtract
   function automatic logic [35:0] mv_times_d(input logic [15:0] x);
      logic [35:0] wide;
      wide = 36'(x);
      return ((wide << ADC_BITS) - wide) << 8;
   endfunction

endpackage

`default_nettype wire

### rtl/core/pas_csr.sv
`default_nettype none

module pas_csr (
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           csr_valid,
   output logic                csr_ready,
   input  wire logic [2:0]     csr_index,
   input  wire logic [15:0]    csr_data,
   output pas_pkg::cfg_type    cfg
);
   import pas_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;
   logic    wr;

   // writes are taken at any time
   assign csr_ready = 1'b1;
   assign wr        = csr_valid;

   // register decode
   always_comb begin
      cfg_in = cfg_ff;
      if (wr) begin
         unique case (csr_index)
            REG_PERIOD:  cfg_in.period_ms        = csr_data;
            REG_REF_MV:  cfg_in.ref_mv           = csr_data[12:0];
            REG_GAIN:    cfg_in.gain_q8          = csr_data;
            REG_ZERO_MV: cfg_in.zero_mv          = csr_data;
            REG_FULL_MV: cfg_in.full_mv          = csr_data;
            REG_FULL_SC: cfg_in.full_scale_centi = csr_data;
            default:     cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.period_ms        <= RST_PERIOD;
         cfg_ff.ref_mv           <= RST_REF_MV;
         cfg_ff.gain_q8          <= RST_GAIN;
         cfg_ff.zero_mv          <= RST_ZERO_MV;
         cfg_ff.full_mv          <= RST_FULL_MV;
         cfg_ff.full_scale_centi <= RST_FULL_SC;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

### rtl/core/pas_ctrl.sv
`default_nettype none

module pas_ctrl (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   input  wire pas_pkg::sts_type sts,
   output pas_pkg::cmd_type  cmd
);
   import pas_pkg::*;

   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_MUL_A = 4'd1;
   localparam logic [3:0] S_MUL_B = 4'd2;
   localparam logic [3:0] S_DIFF  = 4'd3;
   localparam logic [3:0] S_MUL_C = 4'd4;
   localparam logic [3:0] S_SUM   = 4'd5;
   localparam logic [3:0] S_DIV   = 4'd6;
   localparam logic [3:0] S_WR    = 4'd7;
   localparam logic [3:0] S_DONE  = 4'd8;

   logic [3:0]           state_ff, state_in;
   logic [DIV_CNT_W-1:0] div_cnt_ff, div_cnt_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 accept;
   logic                 slot_free;

   assign req_tready = (state_ff == S_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign slot_free  = !rsp_valid_ff || rsp_tready;

   // sequencer
   always_comb begin
      state_in   = state_ff;
      div_cnt_in = div_cnt_ff;
      cmd        = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               cmd.accept = 1'b1;
               state_in   = sts.finish ? S_MUL_A : S_DONE;
            end
         end
         S_MUL_A: begin
            cmd.mul_a = 1'b1;
            state_in  = S_MUL_B;
         end
         S_MUL_B: begin
            cmd.mul_b = 1'b1;
            state_in  = S_DIFF;
         end
         S_DIFF: begin
            cmd.diff = 1'b1;
            state_in = S_MUL_C;
         end
         S_MUL_C: begin
            cmd.mul_c = 1'b1;
            state_in  = S_SUM;
         end
         S_SUM: begin
            cmd.sum    = 1'b1;
            div_cnt_in = '0;
            state_in   = S_DIV;
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            div_cnt_in   = div_cnt_ff + 1'b1;
            if (div_cnt_ff == DIV_CNT_W'(DIV_STEPS - 1)) begin
               state_in = S_WR;
            end
         end
         S_WR: begin
            cmd.write_press = 1'b1;
            state_in        = S_DONE;
         end
         S_DONE: begin
            if (slot_free) begin
               cmd.load_out = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // output beat valid
   always_comb begin
      if (cmd.load_out) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         div_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         div_cnt_ff   <= div_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;

   // checks
   a_plain_item: assert property (@(posedge clock) disable iff (reset)
      accept && !sts.finish |=> state_ff == S_DONE)
      else $error("plain item did not go straight to result");

   a_finish_item: assert property (@(posedge clock) disable iff (reset)
      accept && sts.finish |=> state_ff == S_MUL_A)
      else $error("finishing sample did not start scaling");

   a_write_then_done: assert property (@(posedge clock) disable iff (reset)
      cmd.write_press |=> state_ff == S_DONE)
      else $error("pressure write not followed by result");

   a_load_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.load_out |=> rsp_valid_ff && state_ff == S_IDLE)
      else $error("result load lost");

endmodule

`default_nettype wire

### rtl/core/pas_dp.sv
`default_nettype none

module pas_dp (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire pas_pkg::cfg_type cfg,
   input  wire pas_pkg::cmd_type cmd,
   output pas_pkg::sts_type  sts,
   input  wire logic [1:0]   kind,
   input  wire logic [11:0]  sample,
   output logic [1:0]        out_status,
   output logic [11:0]       out_raw_average,
   output logic [15:0]       out_centi_mpa,
   output logic              out_start,
   output logic              out_updated
);
   import pas_pkg::*;

   // measurement state
   logic [TICK_W-1:0]   elapsed_ff, elapsed_in;
   logic                burst_ff, burst_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic [SUM_W-1:0]    sum_ff, sum_in;
   logic [1:0]          status_ff, status_in;
   logic [ADC_BITS-1:0] avg_ff, avg_in;
   logic                start_ff, start_in;
   logic                upd_ff, upd_in;
   logic [15:0]         press_ff;

   // scaling pipeline
   logic [24:0] prod_a_ff;
   logic [40:0] vnum_ff;
   logic [35:0] znum_ff;
   logic [35:0] den_ff;
   logic        span_ok_ff;
   logic [40:0] diff_ff;
   logic        zero_res_ff;
   logic        clamp_ff;
   logic [36:0] plo_ff;
   logic [35:0] phi_ff;
   logic [36:0] rem_ff;
   logic [15:0] nlo_ff;
   logic [36:0] dvs_ff;
   logic [15:0] q_ff;

   // output register
   logic [1:0]  o_status_ff;
   logic [11:0] o_avg_ff;
   logic [15:0] o_press_ff;
   logic        o_start_ff;
   logic        o_upd_ff;

   logic [TICK_W-1:0] tick_next;
   logic [SUM_W-1:0]  sum_next;
   logic              last_sample;
   logic [40:0]       diff_w;
   logic [56:0]       num_w;
   logic [58:0]       nsum_w;
   logic [37:0]       trial;
   logic              ge;

   assign tick_next   = (&elapsed_ff) ? elapsed_ff : elapsed_ff + 1'b1;
   assign sum_next    = sum_ff + SUM_W'(sample);
   assign last_sample = (count_ff == CNT_W'(AVG_SAMPLES - 1));
   assign sts.finish  = (kind == KIND_SAMPLE) && burst_ff && last_sample;

   // item update
   always_comb begin
      elapsed_in = elapsed_ff;
      burst_in   = burst_ff;
      count_in   = count_ff;
      sum_in     = sum_ff;
      status_in  = status_ff;
      avg_in     = avg_ff;
      start_in   = start_ff;
      upd_in     = upd_ff;
      if (cmd.accept) begin
         start_in = 1'b0;
         upd_in   = 1'b0;
         case (kind)
            KIND_TICK: begin
               elapsed_in = tick_next;
               if (!burst_ff && tick_next >= TICK_W'(cfg.period_ms)) begin
                  elapsed_in = '0;
                  count_in   = '0;
                  sum_in     = '0;
                  burst_in   = 1'b1;
                  start_in   = 1'b1;
               end
            end
            KIND_SAMPLE: begin
               if (burst_ff) begin
                  sum_in   = sum_next;
                  count_in = count_ff + 1'b1;
                  if (!last_sample) begin
                     start_in = 1'b1;
                  end else begin
                     avg_in    = sum_next[SUM_W-1:AVG_SHIFT];
                     status_in = ST_OK;
                     burst_in  = 1'b0;
                     upd_in    = 1'b1;
                  end
               end
            end
            KIND_FAILURE: begin
               if (burst_ff) begin
                  burst_in  = 1'b0;
                  status_in = ST_ERROR;
               end
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         elapsed_ff <= TICK_W'(RST_PERIOD);
         burst_ff   <= 1'b0;
         count_ff   <= '0;
         sum_ff     <= '0;
         status_ff  <= ST_NOT_READY;
         avg_ff     <= '0;
         press_ff   <= '0;
         start_ff   <= 1'b0;
         upd_ff     <= 1'b0;
      end else begin
         elapsed_ff <= elapsed_in;
         burst_ff   <= burst_in;
         count_ff   <= count_in;
         sum_ff     <= sum_in;
         status_ff  <= status_in;
         avg_ff     <= avg_in;
         start_ff   <= start_in;
         upd_ff     <= upd_in;
         if (cmd.write_press) begin
            press_ff <= zero_res_ff ? 16'd0 : (clamp_ff ? cfg.full_scale_centi : q_ff);
         end
      end
   end

   // scaling arithmetic
   assign diff_w = vnum_ff - 41'(znum_ff);
   assign num_w  = 57'(plo_ff) + (57'(phi_ff) << 21);
   assign nsum_w = 59'({num_w, 1'b0}) + 59'(den_ff);
   assign trial  = {rem_ff, nlo_ff[15]};
   assign ge     = trial >= 38'(dvs_ff);

   always_ff @(posedge clock) begin
      // average times reference
      if (cmd.mul_a) begin
         prod_a_ff <= 25'(avg_ff) * 25'(cfg.ref_mv);
      end
      // times gain, offset and span in the same units
      if (cmd.mul_b) begin
         vnum_ff    <= 41'(prod_a_ff) * 41'(cfg.gain_q8);
         znum_ff    <= mv_times_d(cfg.zero_mv);
         den_ff     <= mv_times_d(cfg.full_mv - cfg.zero_mv);
         span_ok_ff <= cfg.full_mv > cfg.zero_mv;
      end
      // above zero and clamp decisions
      if (cmd.diff) begin
         diff_ff     <= diff_w;
         zero_res_ff <= !span_ok_ff || (vnum_ff <= 41'(znum_ff));
         clamp_ff    <= diff_w >= 41'(den_ff);
      end
      // scale by full scale in two partial products
      if (cmd.mul_c) begin
         plo_ff <= 37'(diff_ff[20:0]) * 37'(cfg.full_scale_centi);
         phi_ff <= 36'(diff_ff[40:21]) * 36'(cfg.full_scale_centi);
      end
      // rounded dividend and divisor set up
      if (cmd.sum) begin
         rem_ff <= nsum_w[52:16];
         nlo_ff <= nsum_w[15:0];
         dvs_ff <= {den_ff, 1'b0};
         q_ff   <= '0;
      end
      // one restoring step per cycle
      if (cmd.div_step) begin
         rem_ff <= ge ? 37'(trial - 38'(dvs_ff)) : trial[36:0];
         nlo_ff <= {nlo_ff[14:0], 1'b0};
         q_ff   <= {q_ff[14:0], ge};
      end
      // output register
      if (cmd.load_out) begin
         o_status_ff <= status_ff;
         o_avg_ff    <= avg_ff;
         o_press_ff  <= press_ff;
         o_start_ff  <= start_ff;
         o_upd_ff    <= upd_ff;
      end
   end

   assign out_status      = o_status_ff;
   assign out_raw_average = o_avg_ff;
   assign out_centi_mpa   = o_press_ff;
   assign out_start       = o_start_ff;
   assign out_updated     = o_upd_ff;

endmodule

`default_nettype wire

### rtl/core/pressure_adc_average_scaler_unit.sv
// ticks, failures and most samples go from the idle state to the result state
// a burst-completing sample also takes the scaling states and 16-step restoring divider
// flow: a new item is taken only in the idle state, once the last result is loaded out
// reset: synchronous, active high; configuration and burst registers return to their
// defaults; the tick counter starts at the period, so the first tick opens a burst
`default_nettype none

module pressure_adc_average_scaler_unit (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [15:0] req_tdata,  // sample[11:0], zero pad[15:12]
   input  wire logic [1:0]  req_tuser,  // kind[1:0]
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [31:0]      rsp_tdata,  // raw_average[11:0], centi_mpa[27:12],
                                        // start_conversion[28], updated[29], pad[31:30]
   output logic [1:0]       rsp_tuser,  // status[1:0]
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [2:0]  csr_index,
   input  wire logic [15:0] csr_data
);
   import pas_pkg::*;

   cfg_type     cfg;
   cmd_type     cmd;
   sts_type     sts;
   logic [1:0]  out_status;
   logic [11:0] out_raw_average;
   logic [15:0] out_centi_mpa;
   logic        out_start;
   logic        out_updated;

   pas_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   pas_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   pas_dp u_dp (
      .clock           (clock),
      .reset           (reset),
      .cfg             (cfg),
      .cmd             (cmd),
      .sts             (sts),
      .kind            (req_tuser),
      .sample          (req_tdata[11:0]),
      .out_status      (out_status),
      .out_raw_average (out_raw_average),
      .out_centi_mpa   (out_centi_mpa),
      .out_start       (out_start),
      .out_updated     (out_updated)
   );

   // result beat packing
   assign rsp_tdata = {2'b00, out_updated, out_start, out_centi_mpa, out_raw_average};
   assign rsp_tuser = out_status;

endmodule

`default_nettype wire

### bench/pressure_adc_average_scaler_unit_tb.sv
`default_nettype none

module pressure_adc_average_scaler_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import pas_pkg::*;

   // kind code the block takes no notice of
   localparam logic [1:0] KIND_IGNORED = 2'd3;

   localparam int IDLE_PCT      = 37;
   localparam int SILENCE_LIMIT = 3000;
   localparam int DRAIN_CYCLES  = 40;
   localparam int HOLD_CYCLES   = 400;
   localparam int HOLD_AFTER    = 700;
   localparam int PHASES        = 11;
   localparam int PHASE_ITEMS   = 190;

   // one result beat as seen on the response side
   typedef struct packed {
      logic [1:0]  status;
      logic [11:0] avg;
      logic [15:0] centi;
      logic        start;
      logic        upd;
   } reading_type;

   // directed plan: either a register write or a run of identical input beats
   typedef struct packed {
      logic        is_csr;
      logic [2:0]  reg_idx;
      logic [1:0]  kind;
      logic [15:0] data;
      logic [4:0]  reps;
      logic        known;
      logic [1:0]  st;
      logic [11:0] avg;
      logic [15:0] centi;
      logic        start;
      logic        upd;
   } plan_row_type;

   localparam int PLAN_ROWS = 14;
   localparam plan_row_type PLAN [PLAN_ROWS] = '{
      // sample, failure and unknown kind before any burst
      '{1'b0, REG_PERIOD, KIND_SAMPLE, 16'h0ABC, 5'd1, 1'b1, ST_NOT_READY, 12'd0, 16'd0,
        1'b0, 1'b0},
      '{1'b0, REG_PERIOD, KIND_FAILURE, 16'h0000, 5'd1, 1'b1, ST_NOT_READY, 12'd0, 16'd0,
        1'b0, 1'b0},
      '{1'b0, REG_PERIOD, KIND_IGNORED, 16'h0555, 5'd1, 1'b1, ST_NOT_READY, 12'd0, 16'd0,
        1'b0, 1'b0},
      // first tick after reset opens a burst
      '{1'b0, REG_PERIOD, KIND_TICK, 16'h0000, 5'd1, 1'b1, ST_NOT_READY, 12'd0, 16'd0,
        1'b1, 1'b0},
      '{1'b0, REG_PERIOD, KIND_SAMPLE, 16'h0000, 5'd1, 1'b1, ST_NOT_READY, 12'd0, 16'd0,
        1'b1, 1'b0},
      // failure inside the burst aborts it
      '{1'b0, REG_PERIOD, KIND_FAILURE, 16'h0000, 5'd1, 1'b1, ST_ERROR, 12'd0, 16'd0,
        1'b0, 1'b0},
      '{1'b0, REG_PERIOD, KIND_SAMPLE, 16'h0FFF, 5'd1, 1'b1, ST_ERROR, 12'd0, 16'd0,
        1'b0, 1'b0},
      // zero period
      '{1'b1, REG_PERIOD, KIND_TICK, 16'h0000, 5'd1, 1'b0, ST_NOT_READY, 12'd0, 16'd0,
        1'b0, 1'b0},
      '{1'b0, REG_PERIOD, KIND_TICK, 16'h0000, 5'd1, 1'b1, ST_ERROR, 12'd0, 16'd0,
        1'b1, 1'b0},
      // period already elapsed while the burst runs
      '{1'b0, REG_PERIOD, KIND_TICK, 16'h0000, 5'd1, 1'b1, ST_ERROR, 12'd0, 16'd0,
        1'b0, 1'b0},
      '{1'b0, REG_PERIOD, KIND_SAMPLE, 16'h0FFF, 5'd15, 1'b1, ST_ERROR, 12'd0, 16'd0,
        1'b1, 1'b0},
      // full-scale burst at reset calibration gives 70
      '{1'b0, REG_PERIOD, KIND_SAMPLE, 16'h0FFF, 5'd1, 1'b1, ST_OK, 12'hFFF, 16'd70,
        1'b0, 1'b1},
      '{1'b0, REG_PERIOD, KIND_TICK, 16'h0000, 5'd1, 1'b1, ST_OK, 12'hFFF, 16'd70,
        1'b1, 1'b0},
      // failure keeps the last average and pressure
      '{1'b0, REG_PERIOD, KIND_FAILURE, 16'h0000, 5'd1, 1'b1, ST_ERROR, 12'hFFF, 16'd70,
        1'b0, 1'b0}
   };

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata  = '0;
   logic [1:0]  req_tuser  = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;
   logic [1:0]  rsp_tuser;
   logic        csr_valid  = 1'b0;
   logic        csr_ready;
   logic [2:0]  csr_index  = '0;
   logic [15:0] csr_data   = '0;

   // predictor state
   cfg_type     cfg_now;
   logic [16:0] elapsed;
   logic        burst_on;
   logic [4:0]  sample_cnt;
   logic [15:0] sample_sum;
   logic [1:0]  held_status;
   logic [11:0] held_avg;
   logic [15:0] held_press;

   reading_type awaited_readings[$];
   int     errors        = 0;
   int     readings_seen = 0;
   int     silent_cycles = 0;
   bit     steady        = 1'b0;
   bit     hold_done     = 1'b0;

   pressure_adc_average_scaler_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always #10 clock = ~clock;

   function automatic bit take_break();
      return !steady && ($urandom_range(99) < IDLE_PCT);
   endfunction

   function automatic void reset_predictor();
      cfg_now     = '{RST_PERIOD, RST_REF_MV, RST_GAIN, RST_ZERO_MV, RST_FULL_MV, RST_FULL_SC};
      elapsed     = 17'(RST_PERIOD);
      burst_on    = 1'b0;
      sample_cnt  = '0;
      sample_sum  = '0;
      held_status = ST_NOT_READY;
      held_avg    = '0;
      held_press  = '0;
   endfunction

   // average code to centi-MPa, exact rationals, one round half up after the clamp
   function automatic logic [15:0] to_centi(input logic [11:0] avg);
      longint unsigned full_code, d, volt, offset, num, den;
      full_code = (64'd1 << ADC_BITS) - 64'd1;
      d         = full_code * 64'd256;
      volt      = 64'(avg) * 64'(cfg_now.ref_mv) * 64'(cfg_now.gain_q8);
      offset    = 64'(cfg_now.zero_mv) * d;
      if (cfg_now.full_mv <= cfg_now.zero_mv || volt <= offset) begin
         return '0;
      end
      num = (volt - offset) * 64'(cfg_now.full_scale_centi);
      den = 64'(cfg_now.full_mv - cfg_now.zero_mv) * d;
      if (num >= den * 64'(cfg_now.full_scale_centi)) begin
         return cfg_now.full_scale_centi;
      end
      return 16'((64'd2 * num + den) / (64'd2 * den));
   endfunction

   // advance the burst state by one input beat and give the expected result
   function automatic reading_type advance_sensor(input logic [1:0] kind,
                                                  input logic [11:0] smp);
      reading_type r;
      r.start = 1'b0;
      r.upd   = 1'b0;
      case (kind)
         KIND_TICK: begin
            if (elapsed != '1) begin
               elapsed = elapsed + 17'd1;
            end
            if (!burst_on && elapsed >= 17'(cfg_now.period_ms)) begin
               elapsed    = '0;
               sample_cnt = '0;
               sample_sum = '0;
               burst_on   = 1'b1;
               r.start    = 1'b1;
            end
         end
         KIND_SAMPLE: begin
            if (burst_on) begin
               sample_sum = sample_sum + 16'(smp);
               sample_cnt = sample_cnt + 5'd1;
               if (sample_cnt < AVG_SAMPLES) begin
                  r.start = 1'b1;
               end else begin
                  held_avg    = 12'(sample_sum / AVG_SAMPLES);
                  held_press  = to_centi(held_avg);
                  held_status = ST_OK;
                  burst_on    = 1'b0;
                  r.upd       = 1'b1;
               end
            end
         end
         KIND_FAILURE: begin
            if (burst_on) begin
               burst_on    = 1'b0;
               held_status = ST_ERROR;
            end
         end
         default: ;
      endcase
      r.status = held_status;
      r.avg    = held_avg;
      r.centi  = held_press;
      return r;
   endfunction

   // offer one input beat; the expectation is queued when it is taken
   task automatic put_item(input logic [1:0] kind, input logic [11:0] smp, input bit known,
                           input reading_type typed);
      reading_type predicted;
      @(negedge clock);
      while (take_break()) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= {4'b0, smp};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predicted = advance_sensor(kind, smp);
      awaited_readings.push_back(known ? typed : predicted);
   endtask

   // drop the request side and let the block drain before touching registers
   task automatic settle();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (awaited_readings.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (idx)
         REG_PERIOD:  cfg_now.period_ms        = val;
         REG_REF_MV:  cfg_now.ref_mv           = val[12:0];
         REG_GAIN:    cfg_now.gain_q8          = val;
         REG_ZERO_MV: cfg_now.zero_mv          = val;
         REG_FULL_MV: cfg_now.full_mv          = val;
         REG_FULL_SC: cfg_now.full_scale_centi = val;
         default: ;
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic program_sensor(input cfg_type c);
      write_reg(REG_PERIOD, c.period_ms);
      write_reg(REG_REF_MV, 16'(c.ref_mv));
      write_reg(REG_GAIN, c.gain_q8);
      write_reg(REG_ZERO_MV, c.zero_mv);
      write_reg(REG_FULL_MV, c.full_mv);
      write_reg(REG_FULL_SC, c.full_scale_centi);
   endtask

   // calibration for each phase: extremes and the reset calibration first, then random
   function automatic cfg_type phase_setting(input int p);
      cfg_type c;
      int      roll;
      c.period_ms        = 16'($urandom_range(0, 24));
      c.ref_mv           = 13'($urandom_range(0, 5000));
      roll               = $urandom_range(99);
      c.gain_q8          = (roll < 20) ? 16'($urandom) : 16'($urandom_range(128, 1024));
      c.zero_mv          = 16'($urandom_range(0, 3000));
      roll               = $urandom_range(99);
      c.full_mv          = (roll < 15) ? 16'($urandom_range(0, int'(c.zero_mv)))
                                       : c.zero_mv + 16'($urandom_range(1, 6000));
      roll               = $urandom_range(99);
      c.full_scale_centi = (roll < 10) ? 16'($urandom) : 16'($urandom_range(0, 2000));
      case (p)
         0: c = '{16'd0, 13'd0, 16'd0, 16'd0, 16'd0, 16'd0};
         1: c = '{16'd1, 13'd5000, 16'hFFFF, 16'd0, 16'hFFFF, 16'hFFFF};
         2: begin
            // zero span at the top of the range
            c.period_ms = 16'd2;
            c.zero_mv   = 16'hFFFF;
            c.full_mv   = 16'hFFFF;
         end
         3: c.period_ms = 16'hFFFF;
         4: c = '{16'd5, RST_REF_MV, RST_GAIN, RST_ZERO_MV, RST_FULL_MV, RST_FULL_SC};
         default: ;
      endcase
      return c;
   endfunction

   // mostly complete bursts with a level per burst, plus failures, stray ticks and noise
   task automatic random_traffic(input int count);
      int          n, roll, lvl, val;
      logic [1:0]  kind;
      logic [11:0] smp;
      lvl = 0;
      for (n = 0; n < count; n++) begin
         roll = $urandom_range(99);
         if (burst_on && sample_cnt == 0) begin
            val = $urandom_range(99);
            lvl = (val < 15) ? 0 : (val < 30) ? 4095 : $urandom_range(0, 4095);
         end
         if (roll < 8) begin
            kind = 2'($urandom_range(0, 3));
            smp  = 12'($urandom);
         end else if (burst_on) begin
            if (roll < 11) begin
               kind = KIND_FAILURE;
               smp  = 12'($urandom);
            end else if (roll < 17) begin
               kind = KIND_TICK;
               smp  = 12'($urandom);
            end else begin
               kind = KIND_SAMPLE;
               if ($urandom_range(99) < 10) begin
                  smp = 12'($urandom);
               end else begin
                  val = lvl + $urandom_range(0, 15) - 8;
                  smp = (val < 0) ? 12'd0 : (val > 4095) ? 12'hFFF : 12'(val);
               end
            end
         end else begin
            kind = KIND_TICK;
            smp  = 12'($urandom);
         end
         put_item(kind, smp, 1'b0, '0);
      end
   endtask

   // result side: random back-pressure and one long hold-off
   initial begin
      forever begin
         @(negedge clock);
         if (!hold_done && readings_seen >= HOLD_AFTER) begin
            hold_done = 1'b1;
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
         end
         rsp_tready <= !take_break();
      end
   end

   // compare each result beat with the oldest expectation
   always @(posedge clock) begin
      reading_type got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = '{rsp_tuser, rsp_tdata[11:0], rsp_tdata[27:12], rsp_tdata[28], rsp_tdata[29]};
         readings_seen++;
         if (awaited_readings.size() == 0) begin
            errors++;
            $display("%0t: result beat with none expected, actual %h", $time, got);
         end else begin
            want = awaited_readings.pop_front();
            compare_field("status", want.status, got.status);
            compare_field("raw_average", want.avg, got.avg);
            compare_field("centi_mpa", want.centi, got.centi);
            compare_field("start_conversion", want.start, got.start);
            compare_field("updated", want.upd, got.upd);
         end
      end
   end

   task automatic compare_field(input string what, input int unsigned want,
                                input int unsigned got);
      if (want != got) begin
         errors++;
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
      end
   endtask

   // watchdog on cycles where no beat moves on any channel
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         silent_cycles <= 0;
      end else if (silent_cycles >= SILENCE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end else begin
         silent_cycles <= silent_cycles + 1;
      end
   end

   // stimulus
   initial begin
      int          r, k, p;
      reading_type typed;
      reset_predictor();
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed plan at reset calibration
      for (r = 0; r < PLAN_ROWS; r++) begin
         if (PLAN[r].is_csr) begin
            settle();
            write_reg(PLAN[r].reg_idx, PLAN[r].data);
         end else begin
            typed = '{PLAN[r].st, PLAN[r].avg, PLAN[r].centi, PLAN[r].start, PLAN[r].upd};
            for (k = 0; k < int'(PLAN[r].reps); k++) begin
               put_item(PLAN[r].kind, PLAN[r].data[11:0], PLAN[r].known, typed);
            end
         end
      end

      // random phases, one calibration each
      for (p = 0; p < PHASES; p++) begin
         settle();
         program_sensor(phase_setting(p));
         steady = (p == 5);
         random_traffic((p == 3) ? 60 : PHASE_ITEMS);
      end
      steady = 1'b0;
      settle();

      if (errors == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

`default_nettype wire

### sim.f
rtl/core/pas_pkg.sv
rtl/core/pas_csr.sv
rtl/core/pas_ctrl.sv
rtl/core/pas_dp.sv
rtl/core/pressure_adc_average_scaler_unit.sv
bench/pressure_adc_average_scaler_unit_tb.sv
